// File: hdl/assert_macros.svh
// Assertion macros used by the checker file svpva_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define SVP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define SVP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/svpva_pkg.sv
`default_nettype none

package svpva_pkg;

  localparam int PRICE_BINS    = 1024;
  localparam int MAX_STEPS     = 1000;
  localparam int FRACTION_BITS = 8;

  localparam int TICK_W  = 10;
  localparam int TICKS_W = TICK_W + 1;
  localparam int VOL_W   = 24;
  localparam int BIN_W   = 40;
  localparam int PCT_W   = 7;
  localparam int MODE_W  = 2;
  localparam int STEP_W  = $clog2(MAX_STEPS + 1);
  localparam int QUO_W   = VOL_W + FRACTION_BITS;
  localparam int QCNT_W  = $clog2(QUO_W);
  localparam int GOAL_W  = BIN_W + FRACTION_BITS + PCT_W;
  localparam int APB_DW  = 32;
  localparam int APB_AW  = 3;

  localparam logic [TICKS_W-1:0] MAX_STEPS_T = TICKS_W'(MAX_STEPS);
  localparam logic [PCT_W-1:0]   PCT_RESET   = PCT_W'(70);
  localparam logic [BIN_W-1:0]   BIN_SAT     = '1;

  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ADD    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REPORT = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  localparam logic APB_REG_PCT = 1'b0;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [TICK_W-1:0] bar_low_tick;
    logic [TICK_W-1:0] bar_high_tick;
    logic [VOL_W-1:0]  bar_volume;
  } in_word_t;

  typedef struct packed {
    logic              poc_found;
    logic [TICK_W-1:0] poc_tick;
    logic [TICK_W-1:0] value_high_tick;
    logic [TICK_W-1:0] value_low_tick;
    logic [TICK_W-1:0] session_high_tick;
    logic [TICK_W-1:0] session_low_tick;
    logic [BIN_W-1:0]  total_volume;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_DIV,
    ST_BAR_RD,
    ST_BAR_WR,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_VA_CHK,
    ST_UP_BEGIN,
    ST_DN_BEGIN,
    ST_SRCH_RD,
    ST_SRCH_CHK,
    ST_GROW,
    ST_EMIT
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR_SESS,
    OP_CLR_STEP,
    OP_LOAD_BAR,
    OP_DIV_STEP,
    OP_BAR_RD,
    OP_BAR_WR,
    OP_SCAN_START,
    OP_SCAN_RD,
    OP_SCAN_CMP,
    OP_VA_INIT,
    OP_UP_BEGIN,
    OP_DN_BEGIN,
    OP_SRCH_RD,
    OP_SRCH_CHK,
    OP_TAKE_UP,
    OP_TAKE_DN,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_last;
    logic bar_done;
    logic bar_inverted;
    logic scan_last;
    logic maxv_zero;
    logic up_edge;
    logic dn_edge;
    logic rd_touched;
    logic ptr_edge;
    logic goal_met;
    logic take_up;
    logic up_ok;
  } sts_t;

endpackage

`default_nettype wire

// File: hdl/svpva_ram.sv
`default_nettype none

module svpva_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hdl/svpva_datapath.sv
`default_nettype none

module svpva_datapath #(
  parameter int PRICE_BINS = svpva_pkg::PRICE_BINS
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire svpva_pkg::cmd_t      cmd,
  output      svpva_pkg::sts_t      sts,
  input  wire svpva_pkg::in_word_t  in_data,
  input  wire logic [svpva_pkg::PCT_W-1:0] pct,
  output      svpva_pkg::out_word_t out_data
);

  localparam int ADDR_W = $clog2(PRICE_BINS);
  localparam int TICK_W = svpva_pkg::TICK_W;
  localparam int BIN_W  = svpva_pkg::BIN_W;
  localparam int B_W    = ((ADDR_W > TICK_W) ? ADDR_W : TICK_W) + 1;
  localparam int COV_W  = BIN_W + ADDR_W;
  localparam int C100_W = COV_W + 7;
  localparam int GOAL_W = svpva_pkg::GOAL_W;
  localparam int CMP_W  = (C100_W > GOAL_W) ? C100_W : GOAL_W;
  localparam int QUO_W  = svpva_pkg::QUO_W;
  localparam int TKS_W  = svpva_pkg::TICKS_W;
  localparam int STEP_W = svpva_pkg::STEP_W;
  localparam int FB     = svpva_pkg::FRACTION_BITS;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PRICE_BINS - 1);
  localparam logic [B_W-1:0]    BIN_LIM   = B_W'(PRICE_BINS);

  // memory row: touched mark above the bin volume
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [BIN_W:0]        ram_wdata;
  logic [ADDR_W-1:0]     ram_raddr;
  logic [BIN_W:0]        ram_rdata;
  logic                  rd_touched;
  logic [BIN_W-1:0]      rd_vol;

  svpva_ram #(
    .WIDTH (BIN_W + 1),
    .DEPTH (PRICE_BINS)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_touched = ram_rdata[BIN_W];
  assign rd_vol     = ram_rdata[BIN_W-1:0];

  logic [ADDR_W-1:0]   clr_addr_r, clr_addr_nxt;
  logic [BIN_W-1:0]    total_r, total_nxt;
  logic [TICK_W-1:0]   shigh_r, shigh_nxt;
  logic [TICK_W-1:0]   slow_r, slow_nxt;
  logic                seen_r, seen_nxt;

  logic [QUO_W-1:0]    quo_r, quo_nxt;
  logic [TKS_W-1:0]    rem_r, rem_nxt;
  logic [TKS_W-1:0]    dvsr_r, dvsr_nxt;
  logic [svpva_pkg::QCNT_W-1:0] qcnt_r, qcnt_nxt;
  logic [B_W-1:0]      b_r, b_nxt;
  logic [STEP_W-1:0]   k_r, k_nxt;
  logic [STEP_W-1:0]   cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]   scan_r, scan_nxt;
  logic [BIN_W-1:0]    maxv_r, maxv_nxt;
  logic [ADDR_W-1:0]   poc_r, poc_nxt;
  logic [COV_W-1:0]    cov_r, cov_nxt;
  logic [GOAL_W-1:0]   goal_r, goal_nxt;
  logic [ADDR_W-1:0]   vah_r, vah_nxt;
  logic [ADDR_W-1:0]   val_r, val_nxt;
  logic [ADDR_W-1:0]   up_r, up_nxt;
  logic [ADDR_W-1:0]   dn_r, dn_nxt;
  logic [BIN_W-1:0]    uv_r, uv_nxt;
  logic [BIN_W-1:0]    dv_r, dv_nxt;
  logic                up_ok_r, up_ok_nxt;
  logic [ADDR_W-1:0]   ptr_r, ptr_nxt;
  logic                dir_up_r, dir_up_nxt;
  svpva_pkg::out_word_t out_r, out_nxt;

  logic [TKS_W-1:0]    ticks;
  logic [TKS_W:0]      trial;
  logic [BIN_W:0]      bin_sum;
  logic [BIN_W:0]      tot_sum;
  logic [CMP_W-1:0]    cov_x;
  logic [CMP_W-1:0]    cov100;
  logic                ptr_edge;
  logic                found;
  logic [ADDR_W+TICK_W-1:0] poc_x, vah_x, val_x;

  assign ticks   = TKS_W'(in_data.bar_high_tick) - TKS_W'(in_data.bar_low_tick) + TKS_W'(1);
  assign trial   = {rem_r, quo_r[QUO_W-1]} - {1'b0, dvsr_r};
  assign bin_sum = {1'b0, rd_vol} + (BIN_W + 1)'(quo_r);
  assign tot_sum = {1'b0, total_r} + (BIN_W + 1)'(in_data.bar_volume);
  assign cov_x   = CMP_W'(cov_r);
  assign cov100  = (cov_x << 6) + (cov_x << 5) + (cov_x << 2);
  assign ptr_edge = dir_up_r ? (ptr_r == LAST_ADDR) : (ptr_r == '0);
  assign found   = (maxv_r != '0);
  assign poc_x   = {{TICK_W{1'b0}}, poc_r};
  assign vah_x   = {{TICK_W{1'b0}}, vah_r};
  assign val_x   = {{TICK_W{1'b0}}, val_r};

  always_comb begin
    sts.clr_last     = (clr_addr_r == LAST_ADDR);
    sts.div_last     = (qcnt_r == svpva_pkg::QCNT_W'(QUO_W - 1));
    sts.bar_done     = (k_r == cnt_r) || (b_r >= BIN_LIM);
    sts.bar_inverted = (in_data.bar_high_tick < in_data.bar_low_tick);
    sts.scan_last    = (scan_r == LAST_ADDR);
    sts.maxv_zero    = !found;
    sts.up_edge      = (vah_r == LAST_ADDR);
    sts.dn_edge      = (val_r == '0);
    sts.rd_touched   = rd_touched;
    sts.ptr_edge     = ptr_edge;
    sts.goal_met     = (cov100 >= CMP_W'(goal_r));
    sts.take_up      = (uv_r >= dv_r);
    sts.up_ok        = up_ok_r;
  end

  always_comb begin
    clr_addr_nxt = clr_addr_r;
    total_nxt    = total_r;
    shigh_nxt    = shigh_r;
    slow_nxt     = slow_r;
    seen_nxt     = seen_r;
    quo_nxt      = quo_r;
    rem_nxt      = rem_r;
    dvsr_nxt     = dvsr_r;
    qcnt_nxt     = qcnt_r;
    b_nxt        = b_r;
    k_nxt        = k_r;
    cnt_nxt      = cnt_r;
    scan_nxt     = scan_r;
    maxv_nxt     = maxv_r;
    poc_nxt      = poc_r;
    cov_nxt      = cov_r;
    goal_nxt     = goal_r;
    vah_nxt      = vah_r;
    val_nxt      = val_r;
    up_nxt       = up_r;
    dn_nxt       = dn_r;
    uv_nxt       = uv_r;
    dv_nxt       = dv_r;
    up_ok_nxt    = up_ok_r;
    ptr_nxt      = ptr_r;
    dir_up_nxt   = dir_up_r;
    out_nxt      = out_r;
    ram_we       = 1'b0;
    ram_waddr    = clr_addr_r;
    ram_wdata    = '0;
    ram_raddr    = scan_r;
    case (cmd.op)
      svpva_pkg::OP_CLEAR_SESS: begin
        clr_addr_nxt = '0;
        total_nxt    = '0;
        shigh_nxt    = '0;
        slow_nxt     = '1;
        seen_nxt     = 1'b0;
      end
      svpva_pkg::OP_CLR_STEP: begin
        ram_we       = 1'b1;
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
      end
      svpva_pkg::OP_LOAD_BAR: begin
        quo_nxt   = {in_data.bar_volume, {FB{1'b0}}};
        rem_nxt   = '0;
        dvsr_nxt  = ticks;
        qcnt_nxt  = '0;
        b_nxt     = B_W'(in_data.bar_low_tick);
        k_nxt     = '0;
        cnt_nxt   = (ticks < svpva_pkg::MAX_STEPS_T) ? STEP_W'(ticks)
                                                     : STEP_W'(svpva_pkg::MAX_STEPS);
        total_nxt = tot_sum[BIN_W] ? svpva_pkg::BIN_SAT : tot_sum[BIN_W-1:0];
        if (in_data.bar_high_tick > shigh_r) begin
          shigh_nxt = in_data.bar_high_tick;
        end
        if (in_data.bar_low_tick < slow_r) begin
          slow_nxt = in_data.bar_low_tick;
        end
        seen_nxt  = 1'b1;
      end
      svpva_pkg::OP_DIV_STEP: begin
        if (!trial[TKS_W]) begin
          rem_nxt = trial[TKS_W-1:0];
          quo_nxt = {quo_r[QUO_W-2:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[TKS_W-2:0], quo_r[QUO_W-1]};
          quo_nxt = {quo_r[QUO_W-2:0], 1'b0};
        end
        qcnt_nxt = qcnt_r + svpva_pkg::QCNT_W'(1);
      end
      svpva_pkg::OP_BAR_RD: begin
        ram_raddr = b_r[ADDR_W-1:0];
      end
      svpva_pkg::OP_BAR_WR: begin
        ram_we    = 1'b1;
        ram_waddr = b_r[ADDR_W-1:0];
        ram_wdata = {1'b1, bin_sum[BIN_W] ? svpva_pkg::BIN_SAT : bin_sum[BIN_W-1:0]};
        b_nxt     = b_r + B_W'(1);
        k_nxt     = k_r + STEP_W'(1);
      end
      svpva_pkg::OP_SCAN_START: begin
        scan_nxt = '0;
        maxv_nxt = '0;
        poc_nxt  = '0;
      end
      svpva_pkg::OP_SCAN_RD: begin
        ram_raddr = scan_r;
      end
      svpva_pkg::OP_SCAN_CMP: begin
        if (rd_vol > maxv_r) begin
          maxv_nxt = rd_vol;
          poc_nxt  = scan_r;
        end
        scan_nxt = scan_r + ADDR_W'(1);
      end
      svpva_pkg::OP_VA_INIT: begin
        cov_nxt  = COV_W'(maxv_r);
        vah_nxt  = poc_r;
        val_nxt  = poc_r;
        goal_nxt = GOAL_W'({total_r, {FB{1'b0}}}) * GOAL_W'(pct);
      end
      svpva_pkg::OP_UP_BEGIN: begin
        if (vah_r == LAST_ADDR) begin
          up_ok_nxt = 1'b0;
          uv_nxt    = '0;
        end else begin
          ptr_nxt    = vah_r + ADDR_W'(1);
          dir_up_nxt = 1'b1;
        end
      end
      svpva_pkg::OP_DN_BEGIN: begin
        if (val_r == '0) begin
          dv_nxt = '0;
        end else begin
          ptr_nxt    = val_r - ADDR_W'(1);
          dir_up_nxt = 1'b0;
        end
      end
      svpva_pkg::OP_SRCH_RD: begin
        ram_raddr = ptr_r;
      end
      svpva_pkg::OP_SRCH_CHK: begin
        if (rd_touched) begin
          if (dir_up_r) begin
            up_nxt    = ptr_r;
            uv_nxt    = rd_vol;
            up_ok_nxt = 1'b1;
          end else begin
            dn_nxt = ptr_r;
            dv_nxt = rd_vol;
          end
        end else if (ptr_edge) begin
          if (dir_up_r) begin
            up_ok_nxt = 1'b0;
            uv_nxt    = '0;
          end else begin
            dv_nxt = '0;
          end
        end else begin
          ptr_nxt = dir_up_r ? ptr_r + ADDR_W'(1) : ptr_r - ADDR_W'(1);
        end
      end
      svpva_pkg::OP_TAKE_UP: begin
        cov_nxt = cov_r + COV_W'(uv_r);
        vah_nxt = up_r;
      end
      svpva_pkg::OP_TAKE_DN: begin
        cov_nxt = cov_r + COV_W'(dv_r);
        val_nxt = dn_r;
      end
      svpva_pkg::OP_EMIT: begin
        out_nxt.poc_found         = found;
        out_nxt.poc_tick          = found ? poc_x[TICK_W-1:0] : '0;
        out_nxt.value_high_tick   = found ? vah_x[TICK_W-1:0] : '0;
        out_nxt.value_low_tick    = found ? val_x[TICK_W-1:0] : '0;
        out_nxt.session_high_tick = seen_r ? shigh_r : '0;
        out_nxt.session_low_tick  = seen_r ? slow_r : '0;
        out_nxt.total_volume      = total_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      total_r    <= '0;
      shigh_r    <= '0;
      slow_r     <= '1;
      seen_r     <= 1'b0;
    end else begin
      clr_addr_r <= clr_addr_nxt;
      total_r    <= total_nxt;
      shigh_r    <= shigh_nxt;
      slow_r     <= slow_nxt;
      seen_r     <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r    <= quo_nxt;
    rem_r    <= rem_nxt;
    dvsr_r   <= dvsr_nxt;
    qcnt_r   <= qcnt_nxt;
    b_r      <= b_nxt;
    k_r      <= k_nxt;
    cnt_r    <= cnt_nxt;
    scan_r   <= scan_nxt;
    maxv_r   <= maxv_nxt;
    poc_r    <= poc_nxt;
    cov_r    <= cov_nxt;
    goal_r   <= goal_nxt;
    vah_r    <= vah_nxt;
    val_r    <= val_nxt;
    up_r     <= up_nxt;
    dn_r     <= dn_nxt;
    uv_r     <= uv_nxt;
    dv_r     <= dv_nxt;
    up_ok_r  <= up_ok_nxt;
    ptr_r    <= ptr_nxt;
    dir_up_r <= dir_up_nxt;
    out_r    <= out_nxt;
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

// File: hdl/svpva_ctrl.sv
`default_nettype none

module svpva_ctrl (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output      logic                           in_stall,
  input  wire logic [svpva_pkg::MODE_W-1:0]   in_mode,
  output      logic                           out_valid,
  input  wire logic                           out_stall,
  output      svpva_pkg::cmd_t                cmd,
  input  wire svpva_pkg::sts_t                sts
);

  svpva_pkg::state_t state_r, state_nxt;
  logic              then_dn_r, then_dn_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != svpva_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= svpva_pkg::ST_CLR;
      then_dn_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      then_dn_r   <= then_dn_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    then_dn_nxt   = then_dn_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd.op        = svpva_pkg::OP_NONE;
    case (state_r)
      svpva_pkg::ST_CLR: begin
        cmd.op = svpva_pkg::OP_CLR_STEP;
        if (sts.clr_last) begin
          state_nxt = svpva_pkg::ST_IDLE;
        end
      end
      svpva_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (in_mode)
            svpva_pkg::MODE_CLEAR: begin
              cmd.op    = svpva_pkg::OP_CLEAR_SESS;
              state_nxt = svpva_pkg::ST_CLR;
            end
            svpva_pkg::MODE_ADD: begin
              if (!sts.bar_inverted) begin
                cmd.op    = svpva_pkg::OP_LOAD_BAR;
                state_nxt = svpva_pkg::ST_DIV;
              end
            end
            svpva_pkg::MODE_REPORT: begin
              cmd.op    = svpva_pkg::OP_SCAN_START;
              state_nxt = svpva_pkg::ST_SCAN_RD;
            end
            default: begin
            end
          endcase
        end
      end
      svpva_pkg::ST_DIV: begin
        cmd.op = svpva_pkg::OP_DIV_STEP;
        if (sts.div_last) begin
          state_nxt = svpva_pkg::ST_BAR_RD;
        end
      end
      svpva_pkg::ST_BAR_RD: begin
        if (sts.bar_done) begin
          state_nxt = svpva_pkg::ST_IDLE;
        end else begin
          cmd.op    = svpva_pkg::OP_BAR_RD;
          state_nxt = svpva_pkg::ST_BAR_WR;
        end
      end
      svpva_pkg::ST_BAR_WR: begin
        cmd.op    = svpva_pkg::OP_BAR_WR;
        state_nxt = svpva_pkg::ST_BAR_RD;
      end
      svpva_pkg::ST_SCAN_RD: begin
        cmd.op    = svpva_pkg::OP_SCAN_RD;
        state_nxt = svpva_pkg::ST_SCAN_CMP;
      end
      svpva_pkg::ST_SCAN_CMP: begin
        cmd.op    = svpva_pkg::OP_SCAN_CMP;
        state_nxt = sts.scan_last ? svpva_pkg::ST_VA_CHK : svpva_pkg::ST_SCAN_RD;
      end
      svpva_pkg::ST_VA_CHK: begin
        if (sts.maxv_zero) begin
          state_nxt = svpva_pkg::ST_EMIT;
        end else begin
          cmd.op      = svpva_pkg::OP_VA_INIT;
          then_dn_nxt = 1'b1;
          state_nxt   = svpva_pkg::ST_UP_BEGIN;
        end
      end
      svpva_pkg::ST_UP_BEGIN: begin
        cmd.op = svpva_pkg::OP_UP_BEGIN;
        if (sts.up_edge) begin
          state_nxt = then_dn_r ? svpva_pkg::ST_DN_BEGIN : svpva_pkg::ST_GROW;
        end else begin
          state_nxt = svpva_pkg::ST_SRCH_RD;
        end
      end
      svpva_pkg::ST_DN_BEGIN: begin
        cmd.op      = svpva_pkg::OP_DN_BEGIN;
        then_dn_nxt = 1'b0;
        state_nxt   = sts.dn_edge ? svpva_pkg::ST_GROW : svpva_pkg::ST_SRCH_RD;
      end
      svpva_pkg::ST_SRCH_RD: begin
        cmd.op    = svpva_pkg::OP_SRCH_RD;
        state_nxt = svpva_pkg::ST_SRCH_CHK;
      end
      svpva_pkg::ST_SRCH_CHK: begin
        cmd.op = svpva_pkg::OP_SRCH_CHK;
        if (sts.rd_touched || sts.ptr_edge) begin
          state_nxt = then_dn_r ? svpva_pkg::ST_DN_BEGIN : svpva_pkg::ST_GROW;
        end else begin
          state_nxt = svpva_pkg::ST_SRCH_RD;
        end
      end
      svpva_pkg::ST_GROW: begin
        if (sts.goal_met) begin
          state_nxt = svpva_pkg::ST_EMIT;
        end else if (sts.take_up) begin
          if (!sts.up_ok) begin
            state_nxt = svpva_pkg::ST_EMIT;
          end else begin
            cmd.op    = svpva_pkg::OP_TAKE_UP;
            state_nxt = svpva_pkg::ST_UP_BEGIN;
          end
        end else begin
          cmd.op    = svpva_pkg::OP_TAKE_DN;
          state_nxt = svpva_pkg::ST_DN_BEGIN;
        end
      end
      svpva_pkg::ST_EMIT: begin
        if (out_free) begin
          cmd.op        = svpva_pkg::OP_EMIT;
          out_valid_nxt = 1'b1;
          state_nxt     = svpva_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = svpva_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/session_volume_profile_value_area_core.sv
// Channel  Direction  Handshake             Word
// in_      input      in_valid / in_stall   in_word_t: mode, bar ticks, volume
// out_     output     out_valid / out_stall out_word_t: POC, value area, session
// cfg      APB        psel/penable/pready   value_area_percent at byte address 0
//
// After reset a clearing pass writes every bin, with in_stall high.
// Clear: a new clearing pass over every bin. Add bar: the bit-serial divider first,
// then one memory read and one write per bin covered.
// Report: a scan of every bin for the maximum, then neighbor searches that walk the
// bins next to the value area as it grows by one bin at a time.
// The result sits in an output register; in_ is open again while it waits.
`default_nettype none

module session_volume_profile_value_area_core #(
  parameter int PRICE_BINS = svpva_pkg::PRICE_BINS
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output      logic                                in_stall,
  input  wire svpva_pkg::in_word_t                 in_data,
  output      logic                                out_valid,
  input  wire logic                                out_stall,
  output      svpva_pkg::out_word_t                out_data,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [svpva_pkg::APB_AW-1:0]        paddr,
  input  wire logic [svpva_pkg::APB_DW-1:0]        pwdata,
  output      logic [svpva_pkg::APB_DW-1:0]        prdata,
  output      logic                                pready
);

  logic [svpva_pkg::PCT_W-1:0] pct_r, pct_nxt;
  svpva_pkg::cmd_t             cmd;
  svpva_pkg::sts_t             sts;
  logic                        reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == svpva_pkg::APB_REG_PCT);
  assign prdata  = reg_sel ? svpva_pkg::APB_DW'(pct_r) : '0;

  always_comb begin
    pct_nxt = pct_r;
    if (psel && penable && pwrite && reg_sel) begin
      pct_nxt = pwdata[svpva_pkg::PCT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pct_r <= svpva_pkg::PCT_RESET;
    end else begin
      pct_r <= pct_nxt;
    end
  end

  svpva_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_mode   (in_data.mode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  svpva_datapath #(
    .PRICE_BINS (PRICE_BINS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_data  (in_data),
    .pct      (pct_r),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

// File: hdl/svpva_checker.sv
`default_nettype none
`include "assert_macros.svh"

module svpva_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         out_valid,
  input wire logic                         out_stall,
  input wire svpva_pkg::out_word_t         out_data
);

  logic ticks_zero;
  logic total_zero;

  assign ticks_zero = (out_data.poc_tick == '0) && (out_data.value_high_tick == '0) &&
                      (out_data.value_low_tick == '0);
  assign total_zero = (out_data.total_volume == '0);

  `SVP_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid, "stalled word dropped")
  `SVP_ASSERT_NXT(a_out_stable, out_valid && out_stall, $stable(out_data), "stalled word moved")
  `SVP_ASSERT_IMP(a_nopoc_zero, out_valid && !out_data.poc_found, ticks_zero, "empty profile")
  `SVP_ASSERT_IMP(a_zero_total, out_valid && total_zero, !out_data.poc_found, "POC, no volume")

endmodule

bind session_volume_profile_value_area_core svpva_checker u_svpva_checker (.*);

`default_nettype wire

// File: verif/testbench.sv
`default_nettype none

module testbench;

  localparam int PRICE_BINS = svpva_pkg::PRICE_BINS;
  localparam int MAX_STEPS  = svpva_pkg::MAX_STEPS;
  localparam int FB         = svpva_pkg::FRACTION_BITS;
  localparam int BIN_W      = svpva_pkg::BIN_W;
  localparam int TICK_W     = svpva_pkg::TICK_W;
  localparam int PCT_W      = svpva_pkg::PCT_W;
  localparam int VOL_W      = svpva_pkg::VOL_W;
  localparam int MODE_W     = svpva_pkg::MODE_W;
  localparam int APB_AW     = svpva_pkg::APB_AW;
  localparam int APB_DW     = svpva_pkg::APB_DW;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  svpva_pkg::in_word_t in_data;
  logic out_valid;
  logic out_stall;
  svpva_pkg::out_word_t out_data;
  logic psel, penable, pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;

  session_volume_profile_value_area_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  localparam int IDLE_LIMIT = 200000;

  logic [BIN_W-1:0]  prof_bin [PRICE_BINS];
  logic              prof_touched [PRICE_BINS];
  logic [BIN_W-1:0]  prof_total;
  logic [TICK_W-1:0] prof_high, prof_low;
  logic              prof_seen;
  logic [PCT_W-1:0]  va_percent;

  svpva_pkg::in_word_t  pending_words[$];
  svpva_pkg::out_word_t expected_reports[$];
  int        fail_count;
  int        sent_count;
  int        burst_left, gap_left;
  int        hold_off_cycles;
  logic      pace_enable;
  int        idle_cycles;

  function automatic logic [BIN_W-1:0] sat_add(logic [BIN_W-1:0] a,
                                               logic [BIN_W-1:0] b);
    logic [BIN_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[BIN_W] ? svpva_pkg::BIN_SAT : s[BIN_W-1:0];
  endfunction

  function automatic void queue_word(svpva_pkg::in_word_t w);
    pending_words = {pending_words, w};
  endfunction

  function automatic void clear_profile();
    for (int i = 0; i < PRICE_BINS; i++) begin
      prof_bin[i] = '0;
      prof_touched[i] = 1'b0;
    end
    prof_total = '0;
    prof_high = '0;
    prof_low = '1;
    prof_seen = 1'b0;
  endfunction

  function automatic void add_bar(svpva_pkg::in_word_t w);
    int ticks, count;
    logic [63:0] share;
    if (w.bar_high_tick < w.bar_low_tick) return;
    ticks = int'(w.bar_high_tick) - int'(w.bar_low_tick) + 1;
    share = ({40'd0, w.bar_volume} << FB) / ticks;
    count = ticks < MAX_STEPS ? ticks : MAX_STEPS;
    for (int k = 0; k < count; k++) begin
      if (int'(w.bar_low_tick) + k >= PRICE_BINS) break;
      prof_bin[int'(w.bar_low_tick) + k] =
        sat_add(prof_bin[int'(w.bar_low_tick) + k], share[BIN_W-1:0]);
      prof_touched[int'(w.bar_low_tick) + k] = 1'b1;
    end
    prof_total = sat_add(prof_total, BIN_W'(w.bar_volume));
    if (w.bar_high_tick > prof_high) prof_high = w.bar_high_tick;
    if (w.bar_low_tick < prof_low) prof_low = w.bar_low_tick;
    prof_seen = 1'b1;
  endfunction

  function automatic int next_touched(int i, int dir);
    for (int k = i + dir; k >= 0 && k < PRICE_BINS; k += dir)
      if (prof_touched[k]) return k;
    return -1;
  endfunction

  function automatic svpva_pkg::out_word_t profile_report();
    svpva_pkg::out_word_t r;
    logic [BIN_W-1:0] maxv, uv, dv;
    logic [127:0] covered, goal;
    int poc, up, dn, vah, val;
    maxv = '0;
    poc = 0;
    vah = 0;
    val = 0;
    for (int i = 0; i < PRICE_BINS; i++)
      if (prof_bin[i] > maxv) begin
        maxv = prof_bin[i];
        poc = i;
      end
    if (maxv != 0) begin
      covered = 128'(maxv);
      goal = (128'(prof_total) << FB) * 128'(va_percent);
      up = next_touched(poc, 1);
      dn = next_touched(poc, -1);
      vah = poc;
      val = poc;
      while (covered * 100 < goal) begin
        uv = up >= 0 ? prof_bin[up] : '0;
        dv = dn >= 0 ? prof_bin[dn] : '0;
        if (uv >= dv) begin
          if (up < 0) break;
          covered += 128'(uv);
          vah = up;
          up = next_touched(up, 1);
        end else begin
          covered += 128'(dv);
          val = dn;
          dn = next_touched(dn, -1);
        end
      end
    end
    r.poc_found = maxv != 0;
    r.poc_tick = TICK_W'(poc);
    r.value_high_tick = TICK_W'(vah);
    r.value_low_tick = TICK_W'(val);
    r.session_high_tick = prof_seen ? prof_high : '0;
    r.session_low_tick = prof_seen ? prof_low : '0;
    r.total_volume = prof_total;
    return r;
  endfunction

  function automatic svpva_pkg::in_word_t make_word(logic [MODE_W-1:0] m, int lo, int hi,
                                                    int vol);
    svpva_pkg::in_word_t w;
    w.mode = m;
    w.bar_low_tick = TICK_W'(lo);
    w.bar_high_tick = TICK_W'(hi);
    w.bar_volume = VOL_W'(vol);
    return w;
  endfunction

  function automatic svpva_pkg::in_word_t random_bar();
    int lo, span, sel;
    sel = $urandom_range(0, 19);
    lo = $urandom_range(0, 1023);
    if (sel == 0) span = $urandom_range(0, 1023);
    else span = $urandom_range(0, 12);
    if (sel == 1) return make_word(svpva_pkg::MODE_ADD, lo, $urandom_range(0, 1023), $urandom);
    if (sel == 2) return make_word(svpva_pkg::MODE_ADD, 400 + $urandom_range(0, 200),
                                   400 + $urandom_range(0, 200), $urandom_range(0, 3));
    return make_word(svpva_pkg::MODE_ADD, lo, (lo + span > 1023) ? 1023 : lo + span,
                     (sel < 6) ? $urandom : $urandom_range(0, 5000));
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // sender: bursts and gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        case (in_data.mode)
          svpva_pkg::MODE_CLEAR: clear_profile();
          svpva_pkg::MODE_ADD: add_bar(in_data);
          svpva_pkg::MODE_REPORT: expected_reports = {expected_reports, profile_report()};
          default: ;
        endcase
        sent_count <= sent_count + 1;
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pace_enable && pending_words.size() > 0) begin
        in_data <= pending_words.pop_front();
        in_valid <= 1'b1;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 20);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: own stall pattern plus long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      out_stall <= 1'b1;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 30) && ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_reports.size() == 0) begin
        $error("unexpected report word");
        fail_count <= fail_count + 1;
      end else begin
        svpva_pkg::out_word_t e;
        e = expected_reports.pop_front();
        if (e != out_data) begin
          if (e.poc_found != out_data.poc_found)
            $error("poc_found exp %0d got %0d", e.poc_found, out_data.poc_found);
          if (e.poc_tick != out_data.poc_tick)
            $error("poc_tick exp %0d got %0d", e.poc_tick, out_data.poc_tick);
          if (e.value_high_tick != out_data.value_high_tick)
            $error("value_high_tick exp %0d got %0d", e.value_high_tick,
                   out_data.value_high_tick);
          if (e.value_low_tick != out_data.value_low_tick)
            $error("value_low_tick exp %0d got %0d", e.value_low_tick,
                   out_data.value_low_tick);
          if (e.session_high_tick != out_data.session_high_tick)
            $error("session_high_tick exp %0d got %0d", e.session_high_tick,
                   out_data.session_high_tick);
          if (e.session_low_tick != out_data.session_low_tick)
            $error("session_low_tick exp %0d got %0d", e.session_low_tick,
                   out_data.session_low_tick);
          if (e.total_volume != out_data.total_volume)
            $error("total_volume exp %0d got %0d", e.total_volume, out_data.total_volume);
          fail_count <= fail_count + 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic apb_write(logic [PCT_W-1:0] pct);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= APB_AW'({svpva_pkg::APB_REG_PCT, 2'b00});
    pwdata <= APB_DW'(pct);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    va_percent = pct;
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || in_valid || expected_reports.size() > 0)
      @(posedge clk);
    repeat (3000) @(posedge clk);
  endtask

  task automatic queue_random(int n);
    for (int i = 0; i < n; i++) begin
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) queue_word(make_word(svpva_pkg::MODE_CLEAR, $urandom, $urandom, $urandom));
      else if (r < 5) queue_word(make_word(svpva_pkg::MODE_UNUSED, $urandom, $urandom,
                                           $urandom));
      else if (r < 25) queue_word(make_word(svpva_pkg::MODE_REPORT, $urandom, $urandom,
                                            $urandom));
      else queue_word(random_bar());
    end
  endtask

  initial begin
    logic [PCT_W-1:0] pct_list [6];
    pct_list = '{7'd1, 7'd100, 7'd0, 7'd127, 7'd50, 7'd70};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    fail_count = 0;
    sent_count = 0;
    hold_off_cycles = 0;
    pace_enable = 1'b1;
    idle_cycles = 0;
    va_percent = svpva_pkg::PCT_RESET;
    clear_profile();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    queue_word(make_word(svpva_pkg::MODE_REPORT, 0, 0, 0));
    queue_word(make_word(svpva_pkg::MODE_ADD, 5, 5, 0));
    queue_word(make_word(svpva_pkg::MODE_REPORT, 0, 0, 0));
    queue_word(make_word(svpva_pkg::MODE_ADD, 0, 1023, 24'hFFFFFF));
    queue_word(make_word(svpva_pkg::MODE_ADD, 20, 10, 1000));
    queue_word(make_word(svpva_pkg::MODE_ADD, 1023, 1023, 24'hFFFFFF));
    queue_word(make_word(svpva_pkg::MODE_ADD, 0, 0, 7));
    queue_word(make_word(svpva_pkg::MODE_UNUSED, 1023, 0, 24'hFFFFFF));
    queue_word(make_word(svpva_pkg::MODE_REPORT, 1023, 1023, 24'hFFFFFF));
    queue_word(make_word(svpva_pkg::MODE_CLEAR, 0, 0, 0));
    queue_word(make_word(svpva_pkg::MODE_ADD, 100, 102, 300));
    queue_word(make_word(svpva_pkg::MODE_ADD, 98, 99, 300));
    queue_word(make_word(svpva_pkg::MODE_ADD, 104, 104, 200));
    queue_word(make_word(svpva_pkg::MODE_REPORT, 0, 0, 0));
    queue_word(make_word(svpva_pkg::MODE_CLEAR, 0, 0, 0));
    queue_word(make_word(svpva_pkg::MODE_REPORT, 0, 0, 0));
    drain();

    for (int p = 0; p < 6; p++) begin
      apb_write(pct_list[p]);
      queue_random(140);
      if (p == 1) begin
        hold_off_cycles = 20000;
        queue_word(make_word(svpva_pkg::MODE_REPORT, 0, 0, 0));
        queue_word(make_word(svpva_pkg::MODE_REPORT, 0, 0, 0));
        queue_word(make_word(svpva_pkg::MODE_REPORT, 0, 0, 0));
      end
      if (p == 3) begin
        while (pending_words.size() > 70) @(posedge clk);
        pace_enable = 1'b0;
        @(posedge clk);
        while (in_valid || expected_reports.size() > 0) @(posedge clk);
        pace_enable = 1'b1;
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
